FILE: hdl/xcct_pkg.sv
// xcct_pkg: shared types, character codes and lookahead helpers for the xml tagger
// used by xml_char_class_tagger; depends on nothing else
`default_nettype none

package xcct_pkg;

  localparam int LOOKAHEAD_DEPTH = 9;
  localparam int CNT_W = $clog2(LOOKAHEAD_DEPTH + 1);
  localparam int IDX_W = $clog2(LOOKAHEAD_DEPTH);
  localparam int COMMENT_LEN = 4;
  localparam int DOCTYPE_LEN = 9;

  typedef logic [7:0] char_t;
  typedef char_t [LOOKAHEAD_DEPTH-1:0] la_buf_t;
  typedef logic [CNT_W-1:0] cnt_t;

  typedef enum logic [5:0] {
    MODE_BODY        = 6'b000001,
    MODE_TAG         = 6'b000010,
    MODE_COMMENT     = 6'b000100,
    MODE_PI          = 6'b001000,
    MODE_PROLOG      = 6'b010000,
    MODE_PROLOG_OPEN = 6'b100000
  } mode_t;

  typedef enum logic [2:0] {
    CLS_BODY     = 3'd0,
    CLS_TAG_MARK = 3'd1,
    CLS_TAG_TEXT = 3'd2,
    CLS_COMMENT  = 3'd3,
    CLS_PI       = 3'd4,
    CLS_PROLOG   = 3'd5
  } cls_t;

  typedef enum logic [2:0] {
    CARRY_NONE    = 3'd0,
    CARRY_TAG     = 3'd1,
    CARRY_COMMENT = 3'd2,
    CARRY_PI      = 3'd3,
    CARRY_PROLOG  = 3'd4
  } carry_t;

  localparam logic OP_CHAR = 1'b0;
  localparam logic OP_EOL  = 1'b1;

  localparam char_t CH_LT     = 8'h3C;
  localparam char_t CH_GT     = 8'h3E;
  localparam char_t CH_SLASH  = 8'h2F;
  localparam char_t CH_QUEST  = 8'h3F;
  localparam char_t CH_BANG   = 8'h21;
  localparam char_t CH_DASH   = 8'h2D;
  localparam char_t CH_LBRACK = 8'h5B;
  localparam char_t CH_RBRACK = 8'h5D;

  localparam char_t [0:COMMENT_LEN-1] COMMENT_OPEN = "<!--";
  localparam char_t [0:DOCTYPE_LEN-1] DOCTYPE_OPEN = "<!DOCTYPE";

  // held chars agree with the comment opener as far as both go
  function automatic logic comment_prefix(la_buf_t b, cnt_t n);
    logic ok;
    ok = 1'b1;
    for (int i = 0; i < COMMENT_LEN; i++) begin
      if (cnt_t'(i) < n && b[i] != COMMENT_OPEN[i]) ok = 1'b0;
    end
    return ok;
  endfunction

  function automatic logic doctype_prefix(la_buf_t b, cnt_t n);
    logic ok;
    ok = 1'b1;
    for (int i = 0; i < DOCTYPE_LEN; i++) begin
      if (cnt_t'(i) < n && b[i] != DOCTYPE_OPEN[i]) ok = 1'b0;
    end
    return ok;
  endfunction

  function automatic logic in_block(mode_t m);
    return (m == MODE_COMMENT) || (m == MODE_PI) || (m == MODE_PROLOG) ||
           (m == MODE_PROLOG_OPEN);
  endfunction

  // front of the lookahead cannot be decided until more text arrives
  function automatic logic is_held(la_buf_t b, cnt_t n, mode_t m);
    logic held;
    held = 1'b0;
    if (n == '0) begin
      held = 1'b1;
    end else if (!in_block(m)) begin
      if (b[0] == CH_LT) begin
        if (n < cnt_t'(2)) begin
          held = 1'b1;
        end else if (b[1] == CH_BANG) begin
          if (comment_prefix(b, n)) held = (n < cnt_t'(COMMENT_LEN));
          else held = doctype_prefix(b, n) && (n < cnt_t'(DOCTYPE_LEN));
        end
      end else if (b[0] == CH_SLASH) begin
        held = (n < cnt_t'(2));
      end
    end
    return held;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/xml_char_class_tagger.sv
// xml_char_class_tagger: tags each xml text character with its lexical class
// depends on xcct_pkg (types, character codes, lookahead helpers)
//
// channel   dir  handshake                      contents
// s_axis    in   s_axis_tvalid / s_axis_tready  tdata = ch, tuser = op
// m_axis    out  m_axis_tvalid / m_axis_tready  tdata = class, carry; tuser = line_end
//
// while the output is not stalled, one result leaves per cycle and a character
// that decides one held character is accepted every cycle. a decided opener
// ("</", "<?", "<!--", "<!DOCTYPE") puts out 2, 4 or 9 results and holds input
// until they are out; an end-of-line transaction puts out one result per held
// character plus a line-end report. reset clears the lookahead count and the
// lexer mode; no clearing pass. a stalled output holds the engine and, once the
// current transaction is done, nothing more than the one accepted transaction waits.
`default_nettype none

module xml_char_class_tagger (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       s_axis_tvalid,
  output logic            s_axis_tready,
  input  wire logic [7:0] s_axis_tdata,   // [7:0] ch
  input  wire logic       s_axis_tuser,   // [0] op
  output logic            m_axis_tvalid,
  input  wire logic       m_axis_tready,
  output logic [7:0]      m_axis_tdata,   // [2:0] char_class, [5:3] carry_state, [7:6] zero
  output logic            m_axis_tuser,   // [0] line_end
  output logic            m_axis_tlast
);

  xcct_pkg::la_buf_t la_buf, la_buf_next, buf_shift;
  xcct_pkg::cnt_t    la_cnt, la_cnt_next, cnt_base;
  xcct_pkg::mode_t   lex_mode, mode_next, mode_rep;
  logic              bracket_close, bc_next;
  logic [15:0]       recent_chars;
  xcct_pkg::cnt_t    run_left, act_run, run_after;
  xcct_pkg::cls_t    run_cls, act_cls, cur_cls;
  logic              busy, final_item;

  xcct_pkg::cls_t    out_cls;
  xcct_pkg::carry_t  out_carry, carry_rep;
  logic              out_end, out_last;

  xcct_pkg::char_t   c0, c1, p1, p2;
  logic              held, act_char, act_report, slot_free;
  logic              char_go, report_go, char_last, item_done, accept;

  assign c0 = la_buf[0];
  assign c1 = la_buf[1];
  assign p1 = recent_chars[7:0];
  assign p2 = recent_chars[15:8];
  assign cur_cls = (lex_mode == xcct_pkg::MODE_TAG) ? xcct_pkg::CLS_TAG_TEXT
                                                     : xcct_pkg::CLS_BODY;
  assign held = xcct_pkg::is_held(la_buf, la_cnt, lex_mode);
  assign slot_free = !m_axis_tvalid || m_axis_tready;

  // decide the front of the lookahead
  always_comb begin
    act_char   = 1'b0;
    act_report = 1'b0;
    act_cls    = xcct_pkg::CLS_BODY;
    act_run    = xcct_pkg::cnt_t'(1);
    mode_next  = lex_mode;
    bc_next    = bracket_close;
    if (busy) begin
      if (run_left != '0) begin
        act_char = 1'b1;
        act_cls  = run_cls;
        act_run  = run_left;
      end else if (la_cnt == '0) begin
        act_report = final_item;
      end else if (!held || final_item) begin
        act_char = 1'b1;
        case (lex_mode)
          xcct_pkg::MODE_COMMENT: begin
            act_cls = xcct_pkg::CLS_COMMENT;
            if (c0 == xcct_pkg::CH_GT && p1 == xcct_pkg::CH_DASH && p2 == xcct_pkg::CH_DASH)
              mode_next = xcct_pkg::MODE_BODY;
          end
          xcct_pkg::MODE_PI: begin
            act_cls = xcct_pkg::CLS_PI;
            if (c0 == xcct_pkg::CH_GT && p1 == xcct_pkg::CH_QUEST)
              mode_next = xcct_pkg::MODE_BODY;
          end
          xcct_pkg::MODE_PROLOG: begin
            act_cls = xcct_pkg::CLS_PROLOG;
            if (c0 == xcct_pkg::CH_GT && (!bracket_close || p1 == xcct_pkg::CH_RBRACK))
              mode_next = xcct_pkg::MODE_BODY;
          end
          xcct_pkg::MODE_PROLOG_OPEN: begin
            act_cls = xcct_pkg::CLS_PROLOG;
            if (c0 == xcct_pkg::CH_LBRACK) begin
              bc_next   = 1'b1;
              mode_next = xcct_pkg::MODE_PROLOG;
            end else if (c0 == xcct_pkg::CH_GT) begin
              bc_next   = 1'b0;
              mode_next = xcct_pkg::MODE_BODY;
            end
          end
          default: begin
            if (c0 == xcct_pkg::CH_LT) begin
              if (la_cnt >= xcct_pkg::cnt_t'(2) && c1 == xcct_pkg::CH_SLASH) begin
                act_cls   = xcct_pkg::CLS_TAG_MARK;
                act_run   = xcct_pkg::cnt_t'(2);
                mode_next = xcct_pkg::MODE_TAG;
              end else if (la_cnt >= xcct_pkg::cnt_t'(2) && c1 == xcct_pkg::CH_QUEST) begin
                act_cls   = xcct_pkg::CLS_PI;
                act_run   = xcct_pkg::cnt_t'(2);
                mode_next = xcct_pkg::MODE_PI;
              end else if (la_cnt >= xcct_pkg::cnt_t'(xcct_pkg::COMMENT_LEN) &&
                           xcct_pkg::comment_prefix(la_buf, la_cnt)) begin
                act_cls   = xcct_pkg::CLS_COMMENT;
                act_run   = xcct_pkg::cnt_t'(xcct_pkg::COMMENT_LEN);
                mode_next = xcct_pkg::MODE_COMMENT;
              end else if (la_cnt >= xcct_pkg::cnt_t'(xcct_pkg::DOCTYPE_LEN) &&
                           xcct_pkg::doctype_prefix(la_buf, la_cnt)) begin
                act_cls   = xcct_pkg::CLS_PROLOG;
                act_run   = xcct_pkg::cnt_t'(xcct_pkg::DOCTYPE_LEN);
                mode_next = xcct_pkg::MODE_PROLOG_OPEN;
              end else begin
                // lone or unfinished opener
                act_cls   = xcct_pkg::CLS_TAG_MARK;
                mode_next = xcct_pkg::MODE_TAG;
              end
            end else if (c0 == xcct_pkg::CH_SLASH) begin
              act_cls = (la_cnt >= xcct_pkg::cnt_t'(2) && c1 == xcct_pkg::CH_GT)
                        ? xcct_pkg::CLS_TAG_MARK : cur_cls;
            end else if (c0 == xcct_pkg::CH_GT) begin
              act_cls   = xcct_pkg::CLS_TAG_MARK;
              mode_next = xcct_pkg::MODE_BODY;
            end else begin
              act_cls = cur_cls;
            end
          end
        endcase
      end
    end
  end

  assign buf_shift = xcct_pkg::la_buf_t'(la_buf >> 8);
  assign run_after = act_run - xcct_pkg::cnt_t'(1);

  // last result of a character transaction: the state left behind decides nothing
  assign char_last = !final_item && (run_after == '0) &&
                     xcct_pkg::is_held(buf_shift, la_cnt - xcct_pkg::cnt_t'(1), mode_next);

  assign char_go   = act_char && slot_free;
  assign report_go = act_report && slot_free;
  assign item_done = busy && ((char_go && char_last) || report_go || (!act_char && !act_report));
  assign s_axis_tready = !busy || item_done;
  assign accept = s_axis_tvalid && s_axis_tready;

  // line-end report: an unchosen prolog terminator falls back to '>'
  always_comb begin
    mode_rep = (lex_mode == xcct_pkg::MODE_PROLOG_OPEN) ? xcct_pkg::MODE_PROLOG : lex_mode;
    case (mode_rep)
      xcct_pkg::MODE_TAG:     carry_rep = xcct_pkg::CARRY_TAG;
      xcct_pkg::MODE_COMMENT: carry_rep = xcct_pkg::CARRY_COMMENT;
      xcct_pkg::MODE_PI:      carry_rep = xcct_pkg::CARRY_PI;
      xcct_pkg::MODE_PROLOG:  carry_rep = xcct_pkg::CARRY_PROLOG;
      default:                carry_rep = xcct_pkg::CARRY_NONE;
    endcase
  end

  // lookahead shift and append of an accepted character
  always_comb begin
    la_buf_next = char_go ? buf_shift : la_buf;
    cnt_base    = char_go ? la_cnt - xcct_pkg::cnt_t'(1) : la_cnt;
    la_cnt_next = cnt_base;
    if (accept && s_axis_tuser == xcct_pkg::OP_CHAR &&
        cnt_base < xcct_pkg::cnt_t'(xcct_pkg::LOOKAHEAD_DEPTH)) begin
      la_buf_next[cnt_base[xcct_pkg::IDX_W-1:0]] = s_axis_tdata;
      la_cnt_next = cnt_base + xcct_pkg::cnt_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    la_buf <= la_buf_next;
    if (char_go) begin
      run_cls <= act_cls;
      out_cls <= act_cls;
      out_end <= 1'b0;
      out_carry <= xcct_pkg::CARRY_NONE;
      out_last <= char_last;
    end else if (report_go) begin
      out_cls <= xcct_pkg::CLS_BODY;
      out_end <= 1'b1;
      out_carry <= carry_rep;
      out_last <= 1'b1;
    end
    if (accept) final_item <= (s_axis_tuser == xcct_pkg::OP_EOL);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      la_cnt        <= '0;
      lex_mode      <= xcct_pkg::MODE_BODY;
      bracket_close <= 1'b1;
      recent_chars  <= '0;
      run_left      <= '0;
      busy          <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      la_cnt <= la_cnt_next;
      if (char_go) begin
        lex_mode      <= mode_next;
        bracket_close <= bc_next;
        recent_chars  <= {recent_chars[7:0], c0};
        run_left      <= run_after;
      end else if (report_go) begin
        lex_mode     <= mode_rep;
        if (lex_mode == xcct_pkg::MODE_PROLOG_OPEN) bracket_close <= 1'b0;
        recent_chars <= '0;
      end
      if (accept) busy <= 1'b1;
      else if (item_done) busy <= 1'b0;
      if (char_go || report_go) m_axis_tvalid <= 1'b1;
      else if (m_axis_tready) m_axis_tvalid <= 1'b0;
    end
  end

  assign m_axis_tdata = {2'b00, out_carry, out_cls};
  assign m_axis_tuser = out_end;
  assign m_axis_tlast = out_last;

endmodule

`default_nettype wire
